/* hdl/esc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date: shared package
// Constants, the microcode word layout and the month length table.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int EPOCH_YEAR = 1970;

   localparam int SECONDS_WIDTH = 31;
   localparam int TIME_WIDTH    = 32;
   localparam int OFFSET_WIDTH  = 5;
   localparam int YEAR_WIDTH    = 11;
   localparam int MONTH_WIDTH   = 4;
   localparam int DAY_WIDTH     = 5;
   localparam int HOUR_WIDTH    = 5;
   localparam int MINUTE_WIDTH  = 6;
   localparam int SECOND_WIDTH  = 6;
   localparam int DAYS_WIDTH    = 15;
   localparam int UPC_WIDTH     = 4;

   // Reciprocal multiplier: dividends below 2^30 divided by 15 or by 3.
   localparam int MUL_X_WIDTH   = 30;
   localparam int MUL_K_WIDTH   = 31;
   localparam int PRODUCT_WIDTH = MUL_X_WIDTH + MUL_K_WIDTH;
   localparam logic [MUL_K_WIDTH-1:0] RECIP_15 = 31'd1145324613;
   localparam int RECIP_15_SHIFT = 34;
   localparam logic [MUL_K_WIDTH-1:0] RECIP_3  = 31'd1431655766;
   localparam int RECIP_3_SHIFT  = 32;

   localparam logic [OFFSET_WIDTH-1:0] OFFSET_RESET = 5'd8;
   localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;
   localparam logic [8:0] YEAR_DAYS_COMMON = 9'd365;
   localparam logic [8:0] YEAR_DAYS_LEAP   = 9'd366;
   localparam logic [MONTH_WIDTH-1:0] MONTH_JANUARY  = 4'd1;
   localparam logic [MONTH_WIDTH-1:0] MONTH_FEBRUARY = 4'd2;
   localparam logic [MONTH_WIDTH-1:0] MONTH_DECEMBER = 4'd12;

   // Residues of the epoch year, used to start the leap year counters.
   localparam logic [1:0] EPOCH_MOD_4   = 2'(EPOCH_YEAR % 4);
   localparam logic [6:0] EPOCH_MOD_100 = 7'(EPOCH_YEAR % 100);
   localparam logic [8:0] EPOCH_MOD_400 = 9'(EPOCH_YEAR % 400);

   typedef logic [UPC_WIDTH-1:0] upc_type;

   localparam upc_type UPC_IDLE    = 4'd0;
   localparam upc_type UPC_DIV_SEC = 4'd1;
   localparam upc_type UPC_SEC     = 4'd2;
   localparam upc_type UPC_DIV_MIN = 4'd3;
   localparam upc_type UPC_MIN     = 4'd4;
   localparam upc_type UPC_DIV_HR  = 4'd5;
   localparam upc_type UPC_HOUR    = 4'd6;
   localparam upc_type UPC_YEAR    = 4'd7;
   localparam upc_type UPC_MONTH   = 4'd8;
   localparam upc_type UPC_DONE    = 4'd9;

   typedef enum logic [3:0] {
      DP_LOAD,
      DP_DIV60,
      DP_DIV24,
      DP_SEC,
      DP_MIN,
      DP_HOUR,
      DP_YEAR,
      DP_MONTH,
      DP_HOLD
   } dp_op_type;

   typedef enum logic [2:0] {
      JC_NEVER,
      JC_ALWAYS,
      JC_NO_START,
      JC_YEAR_OVER,
      JC_MONTH_OVER
   } jump_cond_type;

   typedef struct packed {
      dp_op_type     op;
      jump_cond_type cond;
      upc_type       target;
      logic          emit;
   } ucode_word_type;

   typedef struct packed {
      logic year_over;
      logic month_over;
   } dp_status_type;

   function automatic logic [DAY_WIDTH-1:0] month_days(input logic [MONTH_WIDTH-1:0] m);
      logic [DAY_WIDTH-1:0] d;
      unique case (m)
         4'd2:                   d = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         default:                d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

/* hdl/epoch_seconds_to_calendar_date.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date
// Converts seconds since 1970-01-01 00:00:00 UTC plus a whole-hour zone
// offset into local year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_epoch_seconds while busy is low; the transfer takes
//   place at that clock edge and busy goes high on the next cycle.
//   Exactly one result follows: rsp_valid is high for a single cycle with all
//   rsp_ fields valid, and the transfer completes at the end of that cycle.
//   The receiver cannot stall; it must take the result in that cycle.
//   After the accepting edge, three divisions by a constant on one shared
//   reciprocal multiplier, each followed by a step that forms the remainder,
//   split the count into seconds, minutes, hours and days. The year loop and
//   the month loop then step once per year past 1970 and once per month past
//   January, each with one more step to leave, before the result cycle. busy
//   falls right after the result cycle, so a new request is taken only once
//   the previous result has been given.
//   csr_zone_offset_hours is written at any edge with csr_write_enable high,
//   and should only be changed while busy is low.
//   Reset returns the sequencer to idle and the zone offset to 8 hours.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [esc_pkg::SECONDS_WIDTH-1:0]   req_epoch_seconds,
   output logic                                rsp_valid,
   output logic [esc_pkg::YEAR_WIDTH-1:0]      rsp_year,
   output logic [esc_pkg::MONTH_WIDTH-1:0]     rsp_month,
   output logic [esc_pkg::DAY_WIDTH-1:0]       rsp_day_of_month,
   output logic [esc_pkg::HOUR_WIDTH-1:0]      rsp_hour,
   output logic [esc_pkg::MINUTE_WIDTH-1:0]    rsp_minute,
   output logic [esc_pkg::SECOND_WIDTH-1:0]    rsp_second,
   input  logic                                csr_write_enable,
   input  logic [esc_pkg::OFFSET_WIDTH-1:0]    csr_zone_offset_hours
);
   import esc_pkg::*;

   logic [OFFSET_WIDTH-1:0] offset_ff;
   dp_op_type               op;
   dp_status_type           status;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_write_enable) begin
         offset_ff <= csr_zone_offset_hours;
      end
   end

   esc_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy),
      .emit   (rsp_valid)
   );

   esc_datapath u_datapath (
      .clock             (clock),
      .op                (op),
      .epoch_seconds     (req_epoch_seconds),
      .zone_offset_hours (offset_ff),
      .status            (status),
      .year              (rsp_year),
      .month             (rsp_month),
      .day_of_month      (rsp_day_of_month),
      .hour              (rsp_hour),
      .minute            (rsp_minute),
      .second            (rsp_second)
   );

endmodule

/* hdl/esc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date: datapath
// Shared reciprocal multiplier, day counter and year and month stepping logic,
// driven one operation per cycle by the microcode sequencer.
// ----------------------------------------------------------------------------
module esc_datapath (
   input  logic                                   clock,
   input  esc_pkg::dp_op_type                     op,
   input  logic [esc_pkg::SECONDS_WIDTH-1:0]      epoch_seconds,
   input  logic [esc_pkg::OFFSET_WIDTH-1:0]       zone_offset_hours,
   output esc_pkg::dp_status_type                 status,
   output logic [esc_pkg::YEAR_WIDTH-1:0]         year,
   output logic [esc_pkg::MONTH_WIDTH-1:0]        month,
   output logic [esc_pkg::DAY_WIDTH-1:0]          day_of_month,
   output logic [esc_pkg::HOUR_WIDTH-1:0]         hour,
   output logic [esc_pkg::MINUTE_WIDTH-1:0]       minute,
   output logic [esc_pkg::SECOND_WIDTH-1:0]       second
);
   import esc_pkg::*;

   logic [TIME_WIDTH-1:0]   acc_ff, acc_in;
   logic [TIME_WIDTH-1:0]   quo_ff, quo_in;
   logic [DAYS_WIDTH-1:0]   days_ff, days_in;
   logic [YEAR_WIDTH-1:0]   year_ff, year_in;
   logic [MONTH_WIDTH-1:0]  month_ff, month_in;
   logic [1:0]              ymod4_ff, ymod4_in;
   logic [6:0]              ymod100_ff, ymod100_in;
   logic [8:0]              ymod400_ff, ymod400_in;
   logic [SECOND_WIDTH-1:0] sec_ff, sec_in;
   logic [MINUTE_WIDTH-1:0] min_ff, min_in;
   logic [HOUR_WIDTH-1:0]   hour_ff, hour_in;

   logic [16:0]              offset_seconds;
   logic [MUL_X_WIDTH-1:0]   mul_x;
   logic [MUL_K_WIDTH-1:0]   mul_k;
   logic [PRODUCT_WIDTH-1:0] product;
   logic [TIME_WIDTH-1:0]    quotient;
   logic                     leap;
   logic [8:0]               year_len;
   logic [DAY_WIDTH:0]       month_len;

   assign offset_seconds = 17'(zone_offset_hours) * 17'(SECONDS_PER_HOUR);

   // Dividing by 60 is a shift by two and a division by 15; dividing by 24 is
   // a shift by three and a division by 3. Both are exact reciprocal
   // multiplications for the dividends that occur here.
   assign mul_x    = (op == DP_DIV24) ? MUL_X_WIDTH'(acc_ff >> 3)
                                      : acc_ff[TIME_WIDTH-1:2];
   assign mul_k    = (op == DP_DIV24) ? RECIP_3 : RECIP_15;
   assign product  = PRODUCT_WIDTH'(mul_x) * PRODUCT_WIDTH'(mul_k);
   assign quotient = (op == DP_DIV24) ? TIME_WIDTH'(product >> RECIP_3_SHIFT)
                                      : TIME_WIDTH'(product >> RECIP_15_SHIFT);

   assign leap = ((ymod4_ff == 2'd0) && (ymod100_ff != 7'd0)) || (ymod400_ff == 9'd0);
   assign year_len  = leap ? YEAR_DAYS_LEAP : YEAR_DAYS_COMMON;
   assign month_len = {1'b0, month_days(month_ff)}
                      + {5'd0, (leap && (month_ff == MONTH_FEBRUARY))};

   assign status.year_over  = days_ff >= DAYS_WIDTH'(year_len);
   assign status.month_over = (days_ff >= DAYS_WIDTH'(month_len))
                              && (month_ff < MONTH_DECEMBER);

   // Remainders only need their low bits: 60q is congruent to -4q modulo 64
   // and 24q to -8q modulo 32, so adding the scaled quotient gives them.
   always_comb begin
      acc_in     = acc_ff;
      quo_in     = quo_ff;
      days_in    = days_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      ymod4_in   = ymod4_ff;
      ymod100_in = ymod100_ff;
      ymod400_in = ymod400_ff;
      sec_in     = sec_ff;
      min_in     = min_ff;
      hour_in    = hour_ff;
      unique case (op)
         DP_LOAD: begin
            acc_in     = TIME_WIDTH'(epoch_seconds) + TIME_WIDTH'(offset_seconds);
            year_in    = YEAR_WIDTH'(EPOCH_YEAR);
            month_in   = MONTH_JANUARY;
            ymod4_in   = EPOCH_MOD_4;
            ymod100_in = EPOCH_MOD_100;
            ymod400_in = EPOCH_MOD_400;
         end
         DP_DIV60, DP_DIV24: begin
            quo_in = quotient;
         end
         DP_SEC: begin
            sec_in = acc_ff[SECOND_WIDTH-1:0] + {quo_ff[3:0], 2'b00};
            acc_in = quo_ff;
         end
         DP_MIN: begin
            min_in = acc_ff[MINUTE_WIDTH-1:0] + {quo_ff[3:0], 2'b00};
            acc_in = quo_ff;
         end
         DP_HOUR: begin
            hour_in = acc_ff[HOUR_WIDTH-1:0] + {quo_ff[1:0], 3'b000};
            days_in = quo_ff[DAYS_WIDTH-1:0];
         end
         DP_YEAR: begin
            if (status.year_over) begin
               days_in    = days_ff - DAYS_WIDTH'(year_len);
               year_in    = year_ff + 1'b1;
               ymod4_in   = ymod4_ff + 1'b1;
               ymod100_in = (ymod100_ff == 7'd99) ? 7'd0 : ymod100_ff + 1'b1;
               ymod400_in = (ymod400_ff == 9'd399) ? 9'd0 : ymod400_ff + 1'b1;
            end
         end
         DP_MONTH: begin
            if (status.month_over) begin
               days_in  = days_ff - DAYS_WIDTH'(month_len);
               month_in = month_ff + 1'b1;
            end
         end
         DP_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      quo_ff     <= quo_in;
      days_ff    <= days_in;
      year_ff    <= year_in;
      month_ff   <= month_in;
      ymod4_ff   <= ymod4_in;
      ymod100_ff <= ymod100_in;
      ymod400_ff <= ymod400_in;
      sec_ff     <= sec_in;
      min_ff     <= min_in;
      hour_ff    <= hour_in;
   end

   assign year         = year_ff;
   assign month        = month_ff;
   assign day_of_month = days_ff[DAY_WIDTH-1:0] + 1'b1;
   assign hour         = hour_ff;
   assign minute       = min_ff;
   assign second       = sec_ff;

endmodule

/* hdl/esc_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date: microcode sequencer
// Step counter, control store and conditional jump logic.
// ----------------------------------------------------------------------------
module esc_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  esc_pkg::dp_status_type  status,
   output esc_pkg::dp_op_type      op,
   output logic                    busy,
   output logic                    emit
);
   import esc_pkg::*;

   upc_type        upc_ff, upc_in;
   ucode_word_type word;
   logic           take_jump;

   // Control store: each step names a datapath operation and a jump.
   // A taken jump goes to the target; otherwise the step counter advances.
   always_comb begin
      unique case (upc_ff)
         UPC_IDLE:    word = '{op: DP_LOAD,  cond: JC_NO_START,   target: UPC_IDLE,    emit: 1'b0};
         UPC_DIV_SEC: word = '{op: DP_DIV60, cond: JC_NEVER,      target: UPC_IDLE,    emit: 1'b0};
         UPC_SEC:     word = '{op: DP_SEC,   cond: JC_NEVER,      target: UPC_IDLE,    emit: 1'b0};
         UPC_DIV_MIN: word = '{op: DP_DIV60, cond: JC_NEVER,      target: UPC_IDLE,    emit: 1'b0};
         UPC_MIN:     word = '{op: DP_MIN,   cond: JC_NEVER,      target: UPC_IDLE,    emit: 1'b0};
         UPC_DIV_HR:  word = '{op: DP_DIV24, cond: JC_NEVER,      target: UPC_IDLE,    emit: 1'b0};
         UPC_HOUR:    word = '{op: DP_HOUR,  cond: JC_NEVER,      target: UPC_IDLE,    emit: 1'b0};
         UPC_YEAR:    word = '{op: DP_YEAR,  cond: JC_YEAR_OVER,  target: UPC_YEAR,    emit: 1'b0};
         UPC_MONTH:   word = '{op: DP_MONTH, cond: JC_MONTH_OVER, target: UPC_MONTH,   emit: 1'b0};
         UPC_DONE:    word = '{op: DP_HOLD,  cond: JC_ALWAYS,     target: UPC_IDLE,    emit: 1'b1};
         default:     word = '{op: DP_HOLD,  cond: JC_ALWAYS,     target: UPC_IDLE,    emit: 1'b0};
      endcase
   end

   always_comb begin
      unique case (word.cond)
         JC_NEVER:      take_jump = 1'b0;
         JC_ALWAYS:     take_jump = 1'b1;
         JC_NO_START:   take_jump = !start;
         JC_YEAR_OVER:  take_jump = status.year_over;
         JC_MONTH_OVER: take_jump = status.month_over;
         default:       take_jump = 1'b1;
      endcase
   end

   assign upc_in = take_jump ? word.target : upc_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign op   = word.op;
   assign emit = word.emit;
   assign busy = upc_ff != UPC_IDLE;

endmodule
